### rtl/tot_pkg.sv
// ----------------------------------------------------------------------------
// tot_pkg
// shared types and constants of the euler totient block
// ----------------------------------------------------------------------------
`default_nettype none

package tot_pkg;

    localparam int IN_WIDTH      = 32;
    localparam int OUT_WIDTH     = 32;
    localparam int VALUE_WIDTH   = 32;
    localparam int FIRST_DIVISOR = 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_WAIT_CHECK,
        S_STRIP,
        S_WAIT_STRIP,
        S_SCALE,
        S_WAIT_SCALE,
        S_TAIL,
        S_WAIT_TAIL,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_REST_K,
        DIV_ACC_K,
        DIV_ACC_REST
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     rest_take_q;
        logic     acc_update;
        logic     k_inc;
        logic     out_fire;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic q_ge_k;
        logic rem_zero;
        logic rest_one;
        logic rest_zero;
    } status_t;

endpackage

`default_nettype wire

### rtl/tot_div.sv
// ----------------------------------------------------------------------------
// tot_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tot_div #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CW'(W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_next = W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[W-1:0];
            end
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### rtl/tot_dp.sv
// ----------------------------------------------------------------------------
// tot_dp
// datapath: remaining factor, running result, trial divisor and divider
// ----------------------------------------------------------------------------
`default_nettype none

module tot_dp #(
    parameter int VALUE_WIDTH = tot_pkg::VALUE_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tot_pkg::cmd_t                    cmd,
    input  wire logic [tot_pkg::IN_WIDTH-1:0]     value,
    output tot_pkg::status_t                      status,
    output logic [tot_pkg::OUT_WIDTH-1:0]         totient
);

    import tot_pkg::*;

    localparam int W = VALUE_WIDTH;

    logic [W-1:0]         rest_reg, rest_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [W-1:0]         k_reg, k_next;
    logic [OUT_WIDTH-1:0] tot_reg, tot_next;
    logic [W-1:0]         value_w;
    logic [OUT_WIDTH-1:0] acc_out;
    logic [W-1:0]         div_a;
    logic [W-1:0]         div_b;
    logic [W-1:0]         div_q;
    logic [W-1:0]         div_r;
    logic                 div_done;

    generate
        if (W > IN_WIDTH)
        begin : g_in_wide
            assign value_w = {{(W - IN_WIDTH){1'b0}}, value};
        end
        else if (W == IN_WIDTH)
        begin : g_in_same
            assign value_w = value;
        end
        else
        begin : g_in_narrow
            assign value_w = value[W-1:0];
        end

        if (W > OUT_WIDTH)
        begin : g_out_wide
            assign acc_out = acc_reg[OUT_WIDTH-1:0];
        end
        else if (W == OUT_WIDTH)
        begin : g_out_same
            assign acc_out = acc_reg;
        end
        else
        begin : g_out_narrow
            assign acc_out = {{(OUT_WIDTH - W){1'b0}}, acc_reg};
        end
    endgenerate

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_REST_K:
            begin
                div_a = rest_reg;
                div_b = k_reg;
            end
            DIV_ACC_K:
            begin
                div_a = acc_reg;
                div_b = k_reg;
            end
            DIV_ACC_REST:
            begin
                div_a = acc_reg;
                div_b = rest_reg;
            end
            default:
            begin
                div_a = rest_reg;
                div_b = k_reg;
            end
        endcase
    end

    tot_div #(
        .W (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // floor(a/d)*(d-1) = a - q - r
    always_comb
    begin
        rest_next = rest_reg;
        acc_next  = acc_reg;
        k_next    = k_reg;
        tot_next  = tot_reg;
        if (cmd.load)
        begin
            rest_next = value_w;
            acc_next  = value_w;
            k_next    = W'(FIRST_DIVISOR);
        end
        if (cmd.rest_take_q)
        begin
            rest_next = div_q;
        end
        if (cmd.acc_update)
        begin
            acc_next = acc_reg - div_q - div_r;
        end
        if (cmd.k_inc)
        begin
            k_next = k_reg + W'(1);
        end
        if (cmd.out_fire)
        begin
            tot_next = acc_out;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        acc_reg  <= acc_next;
        k_reg    <= k_next;
        tot_reg  <= tot_next;
    end

    assign status.div_done  = div_done;
    assign status.q_ge_k    = (div_q >= k_reg);
    assign status.rem_zero  = (div_r == '0);
    assign status.rest_one  = (rest_reg == W'(1));
    assign status.rest_zero = (rest_reg == '0);
    assign totient          = tot_reg;

endmodule

`default_nettype wire

### rtl/tot_ctrl.sv
// ----------------------------------------------------------------------------
// tot_ctrl
// sequencer for trial division, drives the datapath commands
// ----------------------------------------------------------------------------
`default_nettype none

module tot_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire tot_pkg::status_t status,
    output tot_pkg::cmd_t         cmd,
    output logic                  busy,
    output logic                  done
);

    import tot_pkg::*;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = status.rest_zero ? S_DONE : S_WAIT_CHECK;
            end
            S_WAIT_CHECK:
            begin
                if (status.div_done)
                begin
                    priority if (!status.q_ge_k)
                    begin
                        state_next = S_TAIL;
                    end
                    else if (status.rem_zero)
                    begin
                        state_next = S_STRIP;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_STRIP:
            begin
                state_next = S_WAIT_STRIP;
            end
            S_WAIT_STRIP:
            begin
                if (status.div_done)
                begin
                    state_next = status.rem_zero ? S_STRIP : S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_WAIT_SCALE;
            end
            S_WAIT_SCALE:
            begin
                if (status.div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_TAIL:
            begin
                state_next = status.rest_one ? S_DONE : S_WAIT_TAIL;
            end
            S_WAIT_TAIL:
            begin
                if (status.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = DIV_REST_K;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_CHECK:
            begin
                cmd.div_start = !status.rest_zero;
            end
            S_WAIT_CHECK:
            begin
                if (status.div_done && status.q_ge_k)
                begin
                    cmd.rest_take_q = status.rem_zero;
                    cmd.k_inc       = !status.rem_zero;
                end
            end
            S_STRIP:
            begin
                cmd.div_start = 1'b1;
            end
            S_WAIT_STRIP:
            begin
                cmd.rest_take_q = status.div_done && status.rem_zero;
            end
            S_SCALE:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_ACC_K;
            end
            S_WAIT_SCALE:
            begin
                cmd.acc_update = status.div_done;
                cmd.k_inc      = status.div_done;
            end
            S_TAIL:
            begin
                cmd.div_start = !status.rest_one;
                cmd.div_sel   = DIV_ACC_REST;
            end
            S_WAIT_TAIL:
            begin
                cmd.acc_update = status.div_done;
            end
            S_DONE:
            begin
                cmd.out_fire = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign done_next = cmd.out_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result strobe while still working");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_fire_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_fire |=> !cmd.out_fire)
        else $error("result issued twice for one item");

endmodule

`default_nettype wire

### rtl/euler_totient.sv
// ----------------------------------------------------------------------------
// euler_totient
// euler's totient of an unsigned number by trial division
//
//  channel  ports                 handshake
//  -------  --------------------  ------------------------------------
//  input    value[31:0]           taken when start is high, busy low
//  result   totient[31:0]         valid for one cycle with done high
//
//  each trial division runs on one shared restoring divider, one bit per
//  cycle. the divisions of an item include the one for a leftover factor;
//  worst case a large prime, 2^(VALUE_WIDTH/2) divisions. input 0 skips
//  the divider and goes straight to the result.
//  reset is asynchronous; the block comes up idle with no result pending.
//  the receiver cannot stall; the next item may start in the result cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_totient #(
    parameter int VALUE_WIDTH = tot_pkg::VALUE_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [tot_pkg::IN_WIDTH-1:0] value,
    output logic                              done,
    output logic [tot_pkg::OUT_WIDTH-1:0]     totient
);

    import tot_pkg::*;

    cmd_t    cmd;
    status_t status;

    tot_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tot_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .value   (value),
        .status  (status),
        .totient (totient)
    );

endmodule

`default_nettype wire
